FILE: rtl/core/bcs_pkg.sv
package bcs_pkg;

    localparam int MODE_W  = 4;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;

    typedef enum logic [MODE_W-1:0] {
        MODE_START       = 4'd0,
        MODE_ADVANCE     = 4'd1,
        MODE_TO_END      = 4'd2,
        MODE_INSERT      = 4'd3,
        MODE_ATTACH      = 4'd4,
        MODE_ADD_FRONT   = 4'd5,
        MODE_ADD_END     = 4'd6,
        MODE_REMOVE_CUR  = 4'd7,
        MODE_REMOVE_HEAD = 4'd8
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] current_value;
        logic               has_item;
        logic [COUNT_W-1:0] item_count;
        logic               rejected;
    } rsp_t;

endpackage

FILE: rtl/core/bounded_cursor_sequence.sv
// Bounded list with a cursor.
// Request channel (req_valid / req_stall / req) carries a mode and a value;
// each request applies one list operation: start, advance, move to end,
// insert before cursor, attach after cursor, add front, add end, remove
// current or remove front. Unused mode codes change nothing.
// Response channel (rsp_valid / rsp_stall / rsp) returns exactly one response
// per request, in order: value under the cursor (zero if none), cursor-valid
// flag, item count and a rejected flag (add on full list, or remove with
// nothing to remove).
// A response is registered behind its accepted request: one input register,
// then the list update and the response register.
// Throughput is one request per cycle while rsp_stall is low; all slots shift
// toward or away from the insert/remove slot in parallel: the critical path.
// When rsp_stall is high with a response held, the response stays put, the
// input register keeps its request and req_stall rises once it is occupied.
// Reset empties the list and drops the cursor; slot contents are not cleared
// (only slots below the count are ever read).
module bounded_cursor_sequence #(
    parameter int CAPACITY_N = 32,
    parameter int DATA_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bcs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bcs_pkg::rsp_t rsp
);
    import bcs_pkg::*;

    localparam int IW = $clog2(CAPACITY_N);
    localparam int CW = $clog2(CAPACITY_N + 1);
    localparam int SW = (DATA_BITS < VALUE_W) ? DATA_BITS : VALUE_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY_N);

    logic          s1_valid_reg;
    req_t          s1_reg;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    logic [SW-1:0] slots_reg  [CAPACITY_N];
    logic [SW-1:0] slots_next [CAPACITY_N];
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic          cv_reg, cv_next;

    logic          advance;
    logic          take;
    logic          fire;
    logic          full;
    logic          ins_en;
    logic          rem_en;
    logic [IW-1:0] pos;
    logic [SW-1:0] din;
    logic          rej;
    logic          has_c;
    rsp_t          rsp_c;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = s1_valid_reg && !advance;
    assign take      = req_valid && !req_stall;
    assign fire      = s1_valid_reg && advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full = (count_reg == CAP_C);
    assign din  = SW'(s1_reg.value);

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        cv_next     = cv_reg;
        rej         = 1'b0;
        ins_en      = 1'b0;
        rem_en      = 1'b0;
        pos         = '0;

        case (mode_t'(s1_reg.mode))
            MODE_START:
            begin
                if (count_reg != '0)
                begin
                    cursor_next = '0;
                    cv_next     = 1'b1;
                end
            end
            MODE_ADVANCE:
            begin
                if (cv_reg)
                begin
                    if (CW'(cursor_reg) + CW'(1) < count_reg)
                        cursor_next = cursor_reg + IW'(1);
                    else
                        cv_next = 1'b0;
                end
            end
            MODE_TO_END:
            begin
                if (count_reg != '0)
                begin
                    cursor_next = IW'(count_reg - CW'(1));
                    cv_next     = 1'b1;
                end
                else
                    cv_next = 1'b0;
            end
            MODE_INSERT:
            begin
                if (full)
                    rej = 1'b1;
                else
                begin
                    ins_en      = 1'b1;
                    pos         = cv_reg ? cursor_reg : '0;
                    cursor_next = pos;
                    cv_next     = 1'b1;
                end
            end
            MODE_ATTACH:
            begin
                if (full)
                    rej = 1'b1;
                else
                begin
                    ins_en      = 1'b1;
                    pos         = cv_reg ? cursor_reg + IW'(1) : IW'(count_reg);
                    cursor_next = pos;
                    cv_next     = 1'b1;
                end
            end
            MODE_ADD_FRONT:
            begin
                if (full)
                    rej = 1'b1;
                else
                begin
                    ins_en = 1'b1;
                    pos    = '0;
                    if (cv_reg)
                        cursor_next = cursor_reg + IW'(1);
                end
            end
            MODE_ADD_END:
            begin
                if (full)
                    rej = 1'b1;
                else
                begin
                    ins_en = 1'b1;
                    pos    = IW'(count_reg);
                end
            end
            MODE_REMOVE_CUR:
            begin
                if (!cv_reg || CW'(cursor_reg) >= count_reg)
                    rej = 1'b1;
                else
                begin
                    rem_en = 1'b1;
                    pos    = cursor_reg;
                    // removed the tail item: nothing follows
                    if (CW'(cursor_reg) >= count_reg - CW'(1))
                    begin
                        cv_next     = 1'b0;
                        cursor_next = '0;
                    end
                end
            end
            MODE_REMOVE_HEAD:
            begin
                if (count_reg == '0)
                    rej = 1'b1;
                else
                begin
                    rem_en = 1'b1;
                    pos    = '0;
                    if (cv_reg)
                    begin
                        if (cursor_reg != '0)
                            cursor_next = cursor_reg - IW'(1);
                        else if (count_reg == CW'(1))
                            cv_next = 1'b0;
                    end
                end
            end
            default:
            begin
                rej = 1'b0;
            end
        endcase

        if (ins_en)
            count_next = count_reg + CW'(1);
        else if (rem_en)
            count_next = count_reg - CW'(1);
    end

    // parallel shift: open a gap at pos, or close the slot at pos
    always_comb
    begin
        for (int i = 0; i < CAPACITY_N; i++)
            slots_next[i] = slots_reg[i];
        if (ins_en)
        begin
            for (int i = 1; i < CAPACITY_N; i++)
                if (IW'(i) > pos)
                    slots_next[i] = slots_reg[i-1];
            slots_next[pos] = din;
        end
        else if (rem_en)
        begin
            for (int i = 0; i < CAPACITY_N - 1; i++)
                if (IW'(i) >= pos)
                    slots_next[i] = slots_reg[i+1];
        end
    end

    always_comb
    begin
        has_c               = cv_next && (CW'(cursor_next) < count_next);
        rsp_c.current_value = has_c ? VALUE_W'(slots_next[cursor_next]) : '0;
        rsp_c.has_item      = has_c;
        rsp_c.item_count    = COUNT_W'(count_next);
        rsp_c.rejected      = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            cv_reg        <= 1'b0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                rsp_valid_reg <= s1_valid_reg;
            if (fire)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
                cv_reg     <= cv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_reg <= req;
        if (fire)
        begin
            rsp_reg <= rsp_c;
            for (int i = 0; i < CAPACITY_N; i++)
                slots_reg[i] <= slots_next[i];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("item count above capacity");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg |-> (CW'(cursor_reg) < count_reg))
        else $error("valid cursor beyond list end");

    a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("processed request produced no response");

    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && rej) |=> (count_reg == $past(count_reg)))
        else $error("rejected request changed the count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> ((count_reg == $past(count_reg))
               || (count_reg == $past(count_reg) + CW'(1))
               || (count_reg == $past(count_reg) - CW'(1))))
        else $error("count moved by more than one");

endmodule
